// ===== hw/rtl/ddo_pkg.sv =====
// Shared types, constants and tables for the differential drive odometry unit.
`timescale 1ns / 1ps
package ddo_pkg;

  localparam int CordicSteps = 30;
  localparam logic [20:0] AgeMax = 21'h1FFFFF;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [33:0] AnglePerRad = 34'sd683565276;
  localparam logic [2:0] QueueDepth = 3'd2;

  // Reciprocal of one million scaled by 2^79, rounded up. Exact truncated
  // quotients for every magnitude below 2^59.
  localparam logic [59:0] RecipM = 60'(((80'd1 << 79) + 80'd999999) / 80'd1000000);

  typedef enum logic [1:0] {
    CMD_LEFT  = 2'd0,
    CMD_RIGHT = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_RADIUS  = 2'd0,
    REG_ROS     = 2'd1,
    REG_TIMEOUT = 2'd2
  } reg_idx_t;

  // Work handed from the front to the back: one tick.
  typedef struct packed {
    logic [19:0]        dt;
    logic               stale;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
  } tick_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VEL,
    ST_CORDIC1,
    ST_ROT1,
    ST_MULV,
    ST_PROD,
    ST_DIV,
    ST_ACC,
    ST_CORDIC2,
    ST_QUAT,
    ST_OUT
  } back_state_t;

  function automatic logic [33:0] atan_entry(input logic [4:0] i);
    logic [33:0] r;
    begin
      case (i)
        5'd0: r = 34'd536870912;  5'd1: r = 34'd316933406;
        5'd2: r = 34'd167458907;  5'd3: r = 34'd85004756;
        5'd4: r = 34'd42667331;   5'd5: r = 34'd21354465;
        5'd6: r = 34'd10679838;   5'd7: r = 34'd5340245;
        5'd8: r = 34'd2670163;    5'd9: r = 34'd1335087;
        5'd10: r = 34'd667544;    5'd11: r = 34'd333772;
        5'd12: r = 34'd166886;    5'd13: r = 34'd83443;
        5'd14: r = 34'd41722;     5'd15: r = 34'd20861;
        5'd16: r = 34'd10430;     5'd17: r = 34'd5215;
        5'd18: r = 34'd2608;      5'd19: r = 34'd1304;
        5'd20: r = 34'd652;       5'd21: r = 34'd326;
        5'd22: r = 34'd163;       5'd23: r = 34'd81;
        5'd24: r = 34'd41;        5'd25: r = 34'd20;
        5'd26: r = 34'd10;        5'd27: r = 34'd5;
        5'd28: r = 34'd3;         5'd29: r = 34'd1;
        default: r = 34'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== hw/rtl/ddo_front.sv =====
// Front end: wheel sample registers, ages and the stale decision per tick.
`timescale 1ns / 1ps
module ddo_front import ddo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         cmd,
  input  logic signed [15:0] wheel_speed,
  input  logic [19:0]        elapsed_us,
  input  logic [20:0]        timeout,
  output logic               tick_valid,
  output tick_t              tick
);

  logic signed [15:0] left_speed, right_speed;
  logic [20:0] left_age, right_age;
  logic [21:0] lsum, rsum;
  logic [20:0] lnew, rnew;

  always_comb begin
    lsum = {1'b0, left_age} + {2'b0, elapsed_us};
    rsum = {1'b0, right_age} + {2'b0, elapsed_us};
    lnew = (lsum > {1'b0, AgeMax}) ? AgeMax : lsum[20:0];
    rnew = (rsum > {1'b0, AgeMax}) ? AgeMax : rsum[20:0];
  end

  assign tick_valid = in_valid && (cmd == CMD_TICK);
  assign tick.dt = elapsed_us;
  assign tick.stale = !((lnew < timeout) && (rnew < timeout));
  assign tick.left_speed = left_speed;
  assign tick.right_speed = right_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_speed <= '0;
      right_speed <= '0;
      left_age <= AgeMax;
      right_age <= AgeMax;
    end else if (in_valid) begin
      case (cmd_t'(cmd))
        CMD_LEFT: begin
          left_speed <= (wheel_speed == -16'sd32768) ? 16'sd32767 : -wheel_speed;
          left_age <= '0;
        end
        CMD_RIGHT: begin
          right_speed <= wheel_speed;
          right_age <= '0;
        end
        CMD_TICK: begin
          left_age <= lnew;
          right_age <= rnew;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ddo_queue.sv =====
// Two-entry queue of ticks between the front and the back.
`timescale 1ns / 1ps
module ddo_queue import ddo_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  tick_t wdata,
  output logic  full,
  output logic  empty,
  input  logic  rd,
  output tick_t rdata
);

  tick_t mem [2];
  logic wp, rp;
  logic [2:0] count;

  assign full = (count == QueueDepth);
  assign empty = (count == 3'd0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      count <= count + {2'b0, wr} - {2'b0, rd};
    end
  end

endmodule

// ===== hw/rtl/ddo_back.sv =====
// Back end: velocities, CORDIC sine and cosine, Euler step, quaternion and result register.
`timescale 1ns / 1ps
module ddo_back import ddo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  tick_t              q_data,
  output logic               q_rd,
  input  logic [15:0]        radius,
  input  logic [15:0]        ros,
  output logic               res_valid,
  input  logic               res_pop,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [31:0]        heading,
  output logic signed [15:0] quat_z,
  output logic signed [15:0] quat_w,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] yaw_rate,
  output logic               stale
);

  back_state_t state, state_next;
  tick_t cur;
  logic [4:0] step;
  logic signed [33:0] cx, cy, cz;
  logic [1:0] quad;
  logic signed [31:0] v, vth, vx, vy;
  logic signed [39:0] wq;
  logic signed [33:0] cosv, sinv;
  logic signed [63:0] px, py, pw;
  logic signed [31:0] x_acc, y_acc;
  logic [31:0] h_acc;
  logic [31:0] h_new;
  logic [1:0] phase;
  logic [2:0] pstep;
  logic signed [33:0] xs, ys;
  logic signed [33:0] rx, ry;
  logic signed [16:0] ssum, sdif;
  logic signed [33:0] qz_r, qw_r;
  logic signed [18:0] qz_t, qw_t;
  logic signed [63:0] dsel;
  logic signed [63:0] qdiv;
  logic signed [63:0] padd;
  logic signed [31:0] sat_out;
  logic dneg;
  logic [58:0] dmag;
  logic [118:0] dacc;
  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic [118:0] pp_sh;
  logic [39:0] dquo;
  logic out_full;

  // Quadrant restore of the CORDIC result.
  always_comb begin
    case (quad)
      2'd0: begin rx = cx;  ry = cy;  end
      2'd1: begin rx = -cy; ry = cx;  end
      2'd2: begin rx = -cx; ry = -cy; end
      default: begin rx = cy; ry = -cx; end
    endcase
    xs = cx >>> step;
    ys = cy >>> step;
    ssum = 17'(cur.left_speed) + 17'(cur.right_speed);
    sdif = 17'(cur.right_speed) - 17'(cur.left_speed);
    qz_r = (ry + 34'sd16384) >>> 15;
    qw_r = (rx + 34'sd16384) >>> 15;
    qz_t = (qz_r > 34'sd32767) ? 19'sd32767 :
           (qz_r < -34'sd32768) ? -19'sd32768 : qz_r[18:0];
    qw_t = (qw_r > 34'sd32767) ? 19'sd32767 :
           (qw_r < -34'sd32768) ? -19'sd32768 : qw_r[18:0];
    case (phase)
      2'd0: dsel = px;
      2'd1: dsel = py;
      default: dsel = pw;
    endcase
  end

  // Truncating divide by one million: the magnitude times the scaled
  // reciprocal, built from four 32 by 32 partial products.
  always_comb begin
    pa = (pstep >= 3'd3) ? {5'b0, dmag[58:32]} : dmag[31:0];
    pb = (pstep == 3'd2 || pstep == 3'd4) ? {4'b0, RecipM[59:32]} : RecipM[31:0];
    pp = {32'b0, pa} * {32'b0, pb};
    case (pstep)
      3'd1: pp_sh = {55'b0, pp};
      3'd2, 3'd3: pp_sh = {23'b0, pp, 32'b0};
      3'd4: pp_sh = {pp[54:0], 64'b0};
      default: pp_sh = '0;
    endcase
    dquo = dacc[118:79];
    qdiv = dneg ? -$signed({24'b0, dquo}) : $signed({24'b0, dquo});
    h_new = h_acc + qdiv[31:0];
  end

  always_comb begin
    padd = 64'(x_acc) + qdiv;
    if (phase == 2'd1) padd = 64'(y_acc) + qdiv;
    sat_out = (padd > 64'sd2147483647) ? 32'sh7FFFFFFF :
              (padd < -64'sd2147483648) ? 32'sh80000000 : padd[31:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (!q_empty && !out_full) state_next = ST_VEL;
      ST_VEL:     state_next = cur.stale ? ST_CORDIC2 : ST_CORDIC1;
      ST_CORDIC1: if (step == 5'(CordicSteps - 1)) state_next = ST_ROT1;
      ST_ROT1:    state_next = ST_MULV;
      ST_MULV:    state_next = ST_PROD;
      ST_PROD:    state_next = ST_DIV;
      ST_DIV:     if (pstep == 3'd4) state_next = ST_ACC;
      ST_ACC:     state_next = (phase == 2'd2) ? ST_CORDIC2 : ST_DIV;
      ST_CORDIC2: if (step == 5'(CordicSteps - 1)) state_next = ST_QUAT;
      ST_QUAT:    state_next = ST_OUT;
      ST_OUT:     state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_rd = (state == ST_IDLE) && !q_empty && !out_full;
  end

  assign res_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_full <= 1'b0;
      x_acc <= '0;
      y_acc <= '0;
      h_acc <= '0;
    end else begin
      state <= state_next;
      if (res_pop && out_full) out_full <= 1'b0;
      case (state)
        ST_ACC: begin
          if (phase == 2'd0) x_acc <= sat_out;
          if (phase == 2'd1) y_acc <= sat_out;
          if (phase == 2'd2) h_acc <= h_new;
        end
        ST_OUT: out_full <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur <= q_data;
        // Start the heading CORDIC on the current heading.
        quad <= h_acc[31:30];
        cz <= {4'b0, h_acc[29:0]};
        cx <= CordicGain;
        cy <= '0;
        step <= '0;
      end
      ST_VEL: begin
        v <= 32'((34'($signed({1'b0, radius})) * 34'(ssum)) >>> 9);
        vth <= 32'((34'($signed({1'b0, ros})) * 34'(sdif)) >>> 8);
        vx <= '0;
        vy <= '0;
        if (cur.stale) begin
          quad <= {1'b0, h_acc[31]};
          cz <= {4'b0, h_acc[30:1]};
          cx <= CordicGain;
          cy <= '0;
          step <= '0;
        end
      end
      ST_CORDIC1, ST_CORDIC2: begin
        if (!cz[33]) begin
          cx <= cx - ys; cy <= cy + xs; cz <= cz - $signed(atan_entry(step));
        end else begin
          cx <= cx + ys; cy <= cy - xs; cz <= cz + $signed(atan_entry(step));
        end
        step <= step + 5'd1;
      end
      ST_ROT1: begin
        cosv <= rx;
        sinv <= ry;
      end
      ST_MULV: begin
        vx <= 32'((64'(v) * 64'(cosv)) >>> 30);
        vy <= 32'((64'(v) * 64'(sinv)) >>> 30);
        wq <= 40'((64'(vth) * 64'(AnglePerRad)) >>> 16);
      end
      ST_PROD: begin
        px <= 64'(vx) * 64'($signed({1'b0, cur.dt}));
        py <= 64'(vy) * 64'($signed({1'b0, cur.dt}));
        pw <= 64'(wq) * 64'($signed({1'b0, cur.dt}));
        phase <= 2'd0;
        pstep <= '0;
      end
      ST_DIV: begin
        if (pstep == 3'd0) begin
          dneg <= dsel[63];
          dmag <= dsel[63] ? 59'(-dsel) : dsel[58:0];
          dacc <= '0;
        end else begin
          dacc <= dacc + pp_sh;
        end
        pstep <= pstep + 3'd1;
      end
      ST_ACC: begin
        phase <= phase + 2'd1;
        pstep <= '0;
        // After the heading update, start the CORDIC on half the new heading.
        if (phase == 2'd2) begin
          quad <= {1'b0, h_new[31]};
          cz <= {4'b0, h_new[30:1]};
          cx <= CordicGain;
          cy <= '0;
          step <= '0;
        end
      end
      ST_QUAT: begin
        quat_z <= qz_t[15:0];
        quat_w <= qw_t[15:0];
      end
      ST_OUT: begin
        pos_x <= x_acc;
        pos_y <= y_acc;
        heading <= h_acc;
        vel_x <= cur.stale ? 32'sd0 : vx;
        vel_y <= cur.stale ? 32'sd0 : vy;
        yaw_rate <= cur.stale ? 32'sd0 : vth;
        stale <= cur.stale;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/diff_drive_odometry_unit.sv =====
// Top level of the differential drive odometry unit.
// Order of work: a moving tick runs two 30-step CORDICs and three divides by one million;
//   a stale tick skips the first CORDIC and the divides and runs only the half-heading one.
// The back end works on one tick at a time and starts a tick only once the result register
//   is free; wheel samples are accepted whenever the tick queue is not full.
// Reset is synchronous; it restores the registers, clears pose and marks both wheels stale.
`timescale 1ns / 1ps
module diff_drive_odometry_unit import ddo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         cmd,
  input  logic signed [15:0] wheel_speed,
  input  logic [19:0]        elapsed_us,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [20:0]        cfg_data,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [31:0]        heading,
  output logic signed [15:0] quat_z,
  output logic signed [15:0] quat_w,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] yaw_rate,
  output logic               stale
);

  logic [15:0] radius, ros;
  logic [20:0] timeout;
  logic tick_valid, q_full, q_empty, q_rd, res_valid;
  tick_t tick, q_data;

  // A push is refused only while the tick queue is full; configuration writes are always taken.
  assign full = q_full;
  assign cfg_ready = 1'b1;
  assign empty = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 16'd4057;
      ros <= 16'd9547;
      timeout <= 21'd1000000;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_RADIUS:  radius <= cfg_data[15:0];
        REG_ROS:     ros <= cfg_data[15:0];
        REG_TIMEOUT: timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  ddo_front u_front (
    .clk, .rst, .in_valid(push && !q_full), .cmd, .wheel_speed, .elapsed_us,
    .timeout, .tick_valid, .tick
  );

  ddo_queue u_queue (
    .clk, .rst, .wr(tick_valid), .wdata(tick), .full(q_full), .empty(q_empty),
    .rd(q_rd), .rdata(q_data)
  );

  ddo_back u_back (
    .clk, .rst, .q_empty, .q_data, .q_rd, .radius, .ros, .res_valid,
    .res_pop(pop), .pos_x, .pos_y, .heading, .quat_z, .quat_w, .vel_x, .vel_y,
    .yaw_rate, .stale
  );

endmodule

// ===== hw/rtl/ddo_checker.sv =====
// Port-level checker for the odometry unit and its bind.
`timescale 1ns / 1ps
module ddo_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        stale,
  input logic [31:0] vel_x,
  input logic [31:0] vel_y,
  input logic [31:0] yaw_rate
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");
  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input refused after reset");
  a_stale_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && stale) |-> (vel_x == 0 && vel_y == 0 && yaw_rate == 0))
    else $error("stale result with motion");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result dropped");
  a_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> ($stable(stale) && $stable(vel_x) && $stable(vel_y) &&
                          $stable(yaw_rate)))
    else $error("waiting result changed");

endmodule

bind diff_drive_odometry_unit ddo_checker u_ddo_checker (
  .clk, .rst, .full, .empty, .pop, .stale, .vel_x, .vel_y, .yaw_rate
);
